>>> rtl/md5_message_digest_assert.svh
// Assertion macros shared by the checker.
`ifndef MD5_MESSAGE_DIGEST_ASSERT_SVH
`define MD5_MESSAGE_DIGEST_ASSERT_SVH

// Same-cycle implication, off during reset.
`define MD5_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("md5 assertion failed");

// Next-cycle implication, off during reset.
`define MD5_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("md5 assertion failed");

// Next-cycle implication, always checked.
`define MD5_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("md5 assertion failed");

`endif

>>> rtl/md5_pkg.sv
`timescale 1ns / 1ps

package md5_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       last;
    } t_md5_in;

    typedef struct packed {
        logic [63:0] digest_high;
        logic [63:0] digest_low;
    } t_md5_out;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       is_last;
    } t_md5_cmd;

    typedef struct packed {
        logic     valid;
        t_md5_cmd cmd;
    } t_md5_feed;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ZERO,
        S_LEN,
        S_ROUND,
        S_FIN,
        S_EMIT
    } t_md5_state;

    typedef enum logic [1:0] {
        RET_IDLE,
        RET_PAD,
        RET_ZERO,
        RET_EMIT
    } t_md5_ret;

    localparam int MD5_QDEPTH = 2;

    localparam logic [7:0] MD5_PAD_BYTE   = 8'h80;
    localparam logic [5:0] MD5_LEN_POS    = 6'd56;
    localparam logic [5:0] MD5_LAST_POS   = 6'd63;
    localparam logic [5:0] MD5_LAST_ROUND = 6'd63;
    localparam logic [3:0] MD5_LAST_WORD  = 4'd15;
    localparam logic [3:0] MD5_LEN_LO     = 4'd14;
    localparam logic [3:0] MD5_LEN_HI     = 4'd15;

    localparam logic [31:0] MD5_IV [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    localparam logic [31:0] MD5_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] MD5_R [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    function automatic logic [3:0] md5_msg_index(input logic [5:0] k);
        logic [7:0] t;
        begin
            t = 8'd0;
            case (k[5:4])
                2'd0: t = {4'd0, k[3:0]};
                2'd1: t = {4'd0, k[3:0]} * 8'd5 + 8'd1;
                2'd2: t = {4'd0, k[3:0]} * 8'd3 + 8'd5;
                2'd3: t = {4'd0, k[3:0]} * 8'd7;
                default: t = 8'd0;
            endcase
            return t[3:0];
        end
    endfunction

endpackage

>>> rtl/md5_front.sv
`timescale 1ns / 1ps

module md5_front
    import md5_pkg::*;
#(
    parameter int DEPTH = MD5_QDEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_md5_in   i_item,
    input  logic      i_push,
    output logic      o_full,
    output t_md5_feed o_feed,
    input  logic      i_take
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_md5_cmd        r_mem [DEPTH];
    logic [AW-1:0]   r_wr, n_wr;
    logic [AW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            w_acc;
    logic            w_store;
    logic            w_take;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign w_acc   = i_push && !o_full;
    // drop items that carry neither a byte nor an end mark
    assign w_store = w_acc && (i_item.byte_present || i_item.last);
    assign w_take  = i_take && (r_cnt != '0);

    assign o_feed.valid = (r_cnt != '0);
    assign o_feed.cmd   = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_store) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (w_take) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        case ({w_store, w_take})
            2'b10:   n_cnt = r_cnt + CW'(1);
            2'b01:   n_cnt = r_cnt - CW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_mem[r_wr] <= '{data_byte: i_item.data_byte,
                             has_byte:  i_item.byte_present,
                             is_last:   i_item.last};
        end
    end

endmodule

>>> rtl/md5_core.sv
`timescale 1ns / 1ps

module md5_core
    import md5_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_md5_feed i_feed,
    output logic      o_take,
    input  logic      i_out_ready,
    output logic      o_out_push,
    output t_md5_out  o_digest
);

    t_md5_state   r_state, n_state;
    t_md5_ret     r_ret, n_ret;
    logic [31:0]  r_blk [16];
    logic [31:0]  r_chain [4];
    logic [31:0]  n_chain [4];
    logic [31:0]  r_work [4];
    logic [31:0]  n_work [4];
    logic [63:0]  r_count, n_count;
    logic [5:0]   r_round, n_round;
    logic [3:0]   r_padw, n_padw;
    logic         r_long, n_long;

    logic [5:0]   w_pos;
    logic [31:0]  w_f;
    logic [31:0]  w_sum;
    logic [63:0]  w_dbl;
    logic [31:0]  w_newb;
    logic         w_byte_in;

    assign w_pos     = r_count[8:3];
    assign w_byte_in = i_feed.valid && i_feed.cmd.has_byte;

    always_comb begin
        case (r_round[5:4])
            2'd0:    w_f = (r_work[1] & r_work[2]) | (~r_work[1] & r_work[3]);
            2'd1:    w_f = (r_work[1] & r_work[3]) | (r_work[2] & ~r_work[3]);
            2'd2:    w_f = r_work[1] ^ r_work[2] ^ r_work[3];
            default: w_f = r_work[2] ^ (r_work[1] | ~r_work[3]);
        endcase
        w_sum  = r_work[0] + w_f + MD5_K[r_round] + r_blk[md5_msg_index(r_round)];
        w_dbl  = {w_sum, w_sum} << MD5_R[{r_round[5:4], r_round[1:0]}];
        w_newb = r_work[1] + w_dbl[63:32];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_feed.valid) begin
                    if (i_feed.cmd.has_byte && w_pos == MD5_LAST_POS) begin
                        n_state = S_ROUND;
                    end else if (i_feed.cmd.is_last) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                n_state = (w_pos[5:2] == MD5_LAST_WORD) ? S_ROUND : S_ZERO;
            end
            S_ZERO: begin
                if (r_padw == MD5_LAST_WORD) begin
                    n_state = r_long ? S_ROUND : S_LEN;
                end
            end
            S_LEN: begin
                n_state = S_ROUND;
            end
            S_ROUND: begin
                if (r_round == MD5_LAST_ROUND) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                case (r_ret)
                    RET_PAD:  n_state = S_PAD;
                    RET_ZERO: n_state = S_ZERO;
                    RET_EMIT: n_state = S_EMIT;
                    default:  n_state = S_IDLE;
                endcase
            end
            S_EMIT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_take     = (r_state == S_IDLE) && i_feed.valid;
        o_out_push = (r_state == S_EMIT) && i_out_ready;
        o_digest.digest_low  = {r_chain[1], r_chain[0]};
        o_digest.digest_high = {r_chain[3], r_chain[2]};
    end

    always_comb begin
        n_ret   = r_ret;
        n_count = r_count;
        n_round = r_round;
        n_padw  = r_padw;
        n_long  = r_long;
        n_chain = r_chain;
        n_work  = r_work;
        case (r_state)
            S_IDLE: begin
                if (w_byte_in) begin
                    n_count = r_count + 64'd8;
                    if (w_pos == MD5_LAST_POS) begin
                        n_work  = r_chain;
                        n_round = '0;
                        n_ret   = i_feed.cmd.is_last ? RET_PAD : RET_IDLE;
                    end
                end
            end
            S_PAD: begin
                n_padw = w_pos[5:2] + 4'd1;
                n_long = (w_pos[5:2] != MD5_LAST_WORD) && (w_pos >= MD5_LEN_POS);
                if (w_pos[5:2] == MD5_LAST_WORD) begin
                    n_work  = r_chain;
                    n_round = '0;
                    n_ret   = RET_ZERO;
                end
            end
            S_ZERO: begin
                n_padw = r_padw + 4'd1;
                if (r_padw == MD5_LAST_WORD && r_long) begin
                    n_long  = 1'b0;
                    n_work  = r_chain;
                    n_round = '0;
                    n_ret   = RET_ZERO;
                end
            end
            S_LEN: begin
                n_work  = r_chain;
                n_round = '0;
                n_ret   = RET_EMIT;
            end
            S_ROUND: begin
                n_work[0] = r_work[3];
                n_work[1] = w_newb;
                n_work[2] = r_work[1];
                n_work[3] = r_work[2];
                n_round   = r_round + 6'd1;
            end
            S_FIN: begin
                for (int i = 0; i < 4; i++) begin
                    n_chain[i] = r_chain[i] + r_work[i];
                end
            end
            S_EMIT: begin
                if (i_out_ready) begin
                    n_chain = MD5_IV;
                    n_count = '0;
                    for (int i = 0; i < 4; i++) begin
                        n_work[i] = '0;
                    end
                end
            end
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= RET_IDLE;
            r_count <= '0;
            r_round <= '0;
            r_padw  <= '0;
            r_long  <= 1'b0;
            r_chain <= MD5_IV;
            for (int i = 0; i < 4; i++) begin
                r_work[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_count <= n_count;
            r_round <= n_round;
            r_padw  <= n_padw;
            r_long  <= n_long;
            r_chain <= n_chain;
            r_work  <= n_work;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_byte_in) begin
                    r_blk[w_pos[5:2]][{w_pos[1:0], 3'b000} +: 8] <= i_feed.cmd.data_byte;
                end
            end
            S_PAD: begin
                for (int b = 0; b < 4; b++) begin
                    if (2'(b) == w_pos[1:0]) begin
                        r_blk[w_pos[5:2]][8*b +: 8] <= MD5_PAD_BYTE;
                    end else if (2'(b) > w_pos[1:0]) begin
                        r_blk[w_pos[5:2]][8*b +: 8] <= 8'd0;
                    end
                end
            end
            S_ZERO: begin
                r_blk[r_padw] <= '0;
            end
            S_LEN: begin
                r_blk[MD5_LEN_LO] <= r_count[31:0];
                r_blk[MD5_LEN_HI] <= r_count[63:32];
            end
            default: begin
            end
        endcase
    end

endmodule

>>> rtl/md5_message_digest.sv
`timescale 1ns / 1ps

// channel | fields                              | handshake
// input   | i_item: data_byte, byte_present, last | push / full
// result  | o_result: digest_low, digest_high   | empty / pop
//
// A byte item is written into the block buffer; a 64th byte starts a compression
// (64 rounds of the single round unit, one fold into the chaining words).
// A last item adds up to 18 padding writes, one length write, one or two
// compressions and an emit. Reset is synchronous, active low, no sweep.
// A two-entry input queue and a one-entry result register decouple both sides;
// the core holds at emit while an earlier result is still waiting.
module md5_message_digest
    import md5_pkg::*;
#(
    parameter int QDEPTH = MD5_QDEPTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_md5_in  i_item,
    input  logic     push,
    output logic     full,
    output t_md5_out o_result,
    output logic     empty,
    input  logic     pop
);

    t_md5_feed w_feed;
    logic      w_take;
    logic      w_out_ready;
    logic      w_out_push;
    t_md5_out  w_digest;
    t_md5_out  r_out;
    logic      r_out_valid, n_out_valid;

    md5_front #(
        .DEPTH (QDEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_push  (push),
        .o_full  (full),
        .o_feed  (w_feed),
        .i_take  (w_take)
    );

    md5_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_feed      (w_feed),
        .o_take      (w_take),
        .i_out_ready (w_out_ready),
        .o_out_push  (w_out_push),
        .o_digest    (w_digest)
    );

    assign w_out_ready = !r_out_valid || pop;
    assign empty       = !r_out_valid;
    assign o_result    = r_out;

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_out_push) begin
            n_out_valid = 1'b1;
        end else if (pop && r_out_valid) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_push) begin
            r_out <= w_digest;
        end
    end

endmodule

>>> rtl/md5_message_digest_checker.sv
`timescale 1ns / 1ps

`include "md5_message_digest_assert.svh"

module md5_message_digest_checker
    import md5_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input t_md5_in  i_item,
    input logic     push,
    input logic     full,
    input t_md5_out o_result,
    input logic     empty,
    input logic     pop
);

    `MD5_ASSERT_NOW(a_full_needs_push, i_clk, i_rst_n, $rose(full), $past(push))
    `MD5_ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_result))
    `MD5_ASSERT_NEXT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, empty && !full)
    `MD5_ASSERT_NOW(a_no_full_on_take, i_clk, i_rst_n, $past(!full) && !$past(push), !full)

endmodule

bind md5_message_digest md5_message_digest_checker u_md5_chk (.*);
